>>> hw/rtl/kst_pkg.sv
// ----------------------------------------------------------------------------
// kst_pkg: shared types and constants of the keyword and symbol tokenizer
// Command format between front and back, token kinds, the symbol table and
// the keyword spelling used by the incremental keyword match.
// ----------------------------------------------------------------------------
package kst_pkg;

    localparam int MAX_WORD = 16;
    localparam int LEN_W    = $clog2(MAX_WORD + 1);
    localparam int IDX_W    = $clog2(MAX_WORD);
    localparam int QDEPTH   = 2;
    localparam int QPTR_W   = $clog2(QDEPTH);
    localparam int QCNT_W   = $clog2(QDEPTH + 1);

    localparam logic [4:0] K_END   = 5'd0;
    localparam logic [4:0] K_IDENT = 5'd1;
    localparam logic [4:0] K_WHILE = 5'd2;
    localparam logic [4:0] K_IF    = 5'd3;
    localparam logic [4:0] K_ELSE  = 5'd4;
    localparam logic [4:0] K_SYM0  = 5'd5;
    localparam logic [4:0] K_OTHER = 5'd17;
    localparam logic [4:0] K_BAD   = 5'd18;

    localparam int NSYM = 12;
    localparam logic [7:0] SYM_TABLE [NSYM] = '{
        8'h7B, 8'h7D, 8'h28, 8'h29, 8'h3C, 8'h3E,
        8'h27, 8'h22, 8'h3A, 8'h3B, 8'h2E, 8'h2C
    };

    typedef enum logic [1:0] {
        OP_LETTER,
        OP_SPACE,
        OP_PUNCT,
        OP_END
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [4:0] kind;
        logic [7:0] ch;
    } cmd_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_LOAD,
        BK_WORD,
        BK_TAIL
    } back_state_t;

    function automatic logic is_letter(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return c == 8'h20 || c == 8'h09 || c == 8'h0A || c == 8'h0D;
    endfunction

    function automatic logic [4:0] symbol_kind(input logic [7:0] c);
        logic [4:0] k;
        k = K_BAD;
        if ((c >= 8'd33 && c <= 8'd47) || (c >= 8'd58 && c <= 8'd64))
            k = K_OTHER;
        for (int i = NSYM - 1; i >= 0; i--)
        begin
            if (SYM_TABLE[i] == c)
                k = K_SYM0 + 5'(i);
        end
        return k;
    endfunction

    function automatic logic [7:0] kw_while_char(input logic [LEN_W-1:0] pos);
        logic [7:0] c;
        case (pos)
            LEN_W'(0): c = 8'h77;
            LEN_W'(1): c = 8'h68;
            LEN_W'(2): c = 8'h69;
            LEN_W'(3): c = 8'h6C;
            LEN_W'(4): c = 8'h65;
            default:   c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] kw_if_char(input logic [LEN_W-1:0] pos);
        logic [7:0] c;
        case (pos)
            LEN_W'(0): c = 8'h49;
            LEN_W'(1): c = 8'h46;
            default:   c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] kw_else_char(input logic [LEN_W-1:0] pos);
        logic [7:0] c;
        case (pos)
            LEN_W'(0): c = 8'h45;
            LEN_W'(1): c = 8'h4C;
            LEN_W'(2): c = 8'h53;
            LEN_W'(3): c = 8'h45;
            default:   c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

>>> hw/rtl/kst_front.sv
// ----------------------------------------------------------------------------
// kst_front: input side of the tokenizer
// Accepts source bytes and turns each into a command for the back end.
// ----------------------------------------------------------------------------
module kst_front (
    input  logic           s_tvalid,
    output logic           s_tready,
    input  logic [7:0]     s_tdata,   // [7:0] char_in
    input  logic           s_tlast,   // is_end
    output logic           q_valid,
    input  logic           q_ready,
    output kst_pkg::cmd_t  q_cmd
);
    import kst_pkg::*;

    always_comb
    begin
        q_cmd.ch   = s_tdata;
        q_cmd.kind = symbol_kind(s_tdata);
        if (s_tlast)
        begin
            q_cmd.op   = OP_END;
            q_cmd.kind = K_END;
            q_cmd.ch   = 8'h00;
        end
        else if (is_letter(s_tdata))
            q_cmd.op = OP_LETTER;
        else if (is_space(s_tdata))
            q_cmd.op = OP_SPACE;
        else
            q_cmd.op = OP_PUNCT;
    end

    assign q_valid  = s_tvalid;
    assign s_tready = q_ready;

endmodule

>>> hw/rtl/kst_queue.sv
// ----------------------------------------------------------------------------
// kst_queue: command queue between front and back
// Small register queue that lets the two halves stall independently.
// ----------------------------------------------------------------------------
module kst_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr_valid,
    output logic           wr_ready,
    input  kst_pkg::cmd_t  wr_cmd,
    output logic           rd_valid,
    input  logic           rd_ready,
    output kst_pkg::cmd_t  rd_cmd
);
    import kst_pkg::*;

    cmd_t              slot_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              push, pop;

    assign wr_ready = count_reg != QCNT_W'(QDEPTH);
    assign rd_valid = count_reg != '0;
    assign rd_cmd   = slot_reg[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= wr_cmd;
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(QDEPTH))
        else $error("queue count out of range");

    assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue push lost");

    assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("queue pointers disagree while empty");

endmodule

>>> hw/rtl/kst_back.sv
// ----------------------------------------------------------------------------
// kst_back: execution side of the tokenizer
// Stores letters in the word buffer, tracks keyword matches, and emits word,
// symbol and end tokens through a registered output stage.
// ----------------------------------------------------------------------------
module kst_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           q_valid,
    output logic           q_ready,
    input  kst_pkg::cmd_t  q_cmd,
    output logic           m_tvalid,
    input  logic           m_tready,
    output logic [15:0]    m_tdata,   // [7:0] text_byte, [8] token_end, zero fill
    output logic [5:0]     m_tuser,   // [4:0] token_kind, [5] truncated
    output logic           m_tlast    // run_last
);
    import kst_pkg::*;

    back_state_t      state_reg, state_next;
    logic [LEN_W-1:0] len_reg, len_next;
    logic [LEN_W-1:0] idx_reg, idx_next;
    logic             ovf_reg, ovf_next;
    logic             m_while_reg, m_while_next;
    logic             m_if_reg, m_if_next;
    logic             m_else_reg, m_else_next;
    cmd_t             pend_reg, pend_next;
    logic [4:0]       wkind_reg, wkind_next;

    logic [7:0]       word_mem [MAX_WORD];
    logic [7:0]       rd_data_reg;
    logic [LEN_W-1:0] rd_addr;
    logic             wr_en;

    logic             out_valid_reg;
    logic [7:0]       out_text_reg;
    logic [4:0]       out_kind_reg;
    logic             out_tend_reg, out_trunc_reg, out_last_reg;

    logic             out_ready, load;
    logic [7:0]       ld_text;
    logic [4:0]       ld_kind;
    logic             ld_tend, ld_trunc, ld_last;
    logic             first, word_last;
    logic [4:0]       word_kind;

    assign out_ready = !out_valid_reg || m_tready;
    assign first     = len_reg == '0;
    assign word_last = LEN_W'(idx_reg + 1'b1) == len_reg;
    assign rd_addr   = (state_reg == BK_WORD && out_ready) ? LEN_W'(idx_reg + 1'b1) : idx_reg;

    always_comb
    begin
        word_kind = K_IDENT;
        if (!ovf_reg)
        begin
            if (m_while_reg && len_reg == LEN_W'(5))
                word_kind = K_WHILE;
            else if (m_if_reg && len_reg == LEN_W'(2))
                word_kind = K_IF;
            else if (m_else_reg && len_reg == LEN_W'(4))
                word_kind = K_ELSE;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        len_next     = len_reg;
        idx_next     = idx_reg;
        ovf_next     = ovf_reg;
        m_while_next = m_while_reg;
        m_if_next    = m_if_reg;
        m_else_next  = m_else_reg;
        pend_next    = pend_reg;
        wkind_next   = wkind_reg;
        q_ready      = 1'b0;
        wr_en        = 1'b0;
        load         = 1'b0;
        ld_text      = pend_reg.ch;
        ld_kind      = pend_reg.kind;
        ld_tend      = 1'b1;
        ld_trunc     = 1'b0;
        ld_last      = 1'b1;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (q_valid)
                begin
                    if (q_cmd.op == OP_LETTER)
                    begin
                        q_ready = 1'b1;
                        if (len_reg < LEN_W'(MAX_WORD))
                        begin
                            wr_en        = 1'b1;
                            len_next     = len_reg + 1'b1;
                            m_while_next = (first || m_while_reg)
                                           && q_cmd.ch == kw_while_char(len_reg);
                            m_if_next    = (first || m_if_reg)
                                           && q_cmd.ch == kw_if_char(len_reg);
                            m_else_next  = (first || m_else_reg)
                                           && q_cmd.ch == kw_else_char(len_reg);
                        end
                        else
                            ovf_next = 1'b1;
                    end
                    else if (!first)
                    begin
                        q_ready    = 1'b1;
                        pend_next  = q_cmd;
                        wkind_next = word_kind;
                        idx_next   = '0;
                        state_next = BK_LOAD;
                    end
                    else if (q_cmd.op == OP_SPACE)
                        q_ready = 1'b1;
                    else if (out_ready)
                    begin
                        q_ready = 1'b1;
                        load    = 1'b1;
                        ld_text = q_cmd.ch;
                        ld_kind = q_cmd.kind;
                    end
                end
            end
            BK_LOAD:
                state_next = BK_WORD;
            BK_WORD:
            begin
                if (out_ready)
                begin
                    load     = 1'b1;
                    ld_text  = rd_data_reg;
                    ld_kind  = wkind_reg;
                    ld_tend  = word_last;
                    ld_trunc = ovf_reg;
                    ld_last  = word_last && pend_reg.op == OP_SPACE;
                    idx_next = LEN_W'(idx_reg + 1'b1);
                    if (word_last)
                    begin
                        len_next   = '0;
                        ovf_next   = 1'b0;
                        state_next = (pend_reg.op == OP_SPACE) ? BK_IDLE : BK_TAIL;
                    end
                end
            end
            BK_TAIL:
            begin
                if (out_ready)
                begin
                    load       = 1'b1;
                    state_next = BK_IDLE;
                end
            end
            default:
                state_next = BK_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            len_reg       <= '0;
            idx_reg       <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            len_reg   <= len_next;
            idx_reg   <= idx_next;
            ovf_reg   <= ovf_next;
            if (load)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        m_while_reg <= m_while_next;
        m_if_reg    <= m_if_next;
        m_else_reg  <= m_else_next;
        pend_reg    <= pend_next;
        wkind_reg   <= wkind_next;
        if (load)
        begin
            out_text_reg  <= ld_text;
            out_kind_reg  <= ld_kind;
            out_tend_reg  <= ld_tend;
            out_trunc_reg <= ld_trunc;
            out_last_reg  <= ld_last;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            word_mem[len_reg[IDX_W-1:0]] <= q_cmd.ch;
        rd_data_reg <= word_mem[rd_addr[IDX_W-1:0]];
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'b0, out_tend_reg, out_text_reg};
    assign m_tuser  = {out_trunc_reg, out_kind_reg};
    assign m_tlast  = out_last_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= LEN_W'(MAX_WORD))
        else $error("word length beyond buffer");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BK_WORD) |-> (idx_reg < len_reg))
        else $error("word read past its length");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BK_LOAD) |=> (state_reg == BK_WORD))
        else $error("load cycle not followed by word emission");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BK_TAIL) |-> (pend_reg.op == OP_PUNCT || pend_reg.op == OP_END))
        else $error("tail token without a pending symbol or end");

endmodule

>>> hw/rtl/keyword_symbol_tokenizer_core.sv
// ----------------------------------------------------------------------------
// keyword_symbol_tokenizer_core: keyword and symbol tokenizer
// Source bytes enter on the s_ side, one per item; s_tlast marks the end of
// input, which flushes any pending word and then emits an end token.
// Tokens leave on the m_ side one character per item: m_tuser carries the
// kind and truncated flag, m_tdata the text byte and token_end flag, m_tlast
// the last item caused by one input item.
// The front classifies each byte and drops a command in a two-entry queue;
// s_tready is high whenever the queue has room.
// The back end stores each letter, drops whitespace and emits a lone symbol
// directly; for a word it reads the word buffer in the load state, then sends
// one character per cycle while the output accepts it, and then, unless
// whitespace ended the word, the symbol or end token that ends it.
// The first character of a word passes the load and word states; a lone
// symbol or an end mark with no pending word is loaded straight to output.
// Reset empties the queue, the word buffer length and the output register.
// A stalled m_tready holds the output register; the back end then waits once it
// has a token to emit, and the queue fills, after which s_tready drops.
// ----------------------------------------------------------------------------
module keyword_symbol_tokenizer_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] char_in
    input  logic        s_tlast,   // is_end
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] text_byte, [8] token_end, zero fill
    output logic [5:0]  m_tuser,   // [4:0] token_kind, [5] truncated
    output logic        m_tlast    // run_last
);
    import kst_pkg::*;

    logic fq_valid, fq_ready;
    cmd_t fq_cmd;
    logic qb_valid, qb_ready;
    cmd_t qb_cmd;

    kst_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_valid  (fq_valid),
        .q_ready  (fq_ready),
        .q_cmd    (fq_cmd)
    );

    kst_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (fq_valid),
        .wr_ready (fq_ready),
        .wr_cmd   (fq_cmd),
        .rd_valid (qb_valid),
        .rd_ready (qb_ready),
        .rd_cmd   (qb_cmd)
    );

    kst_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (qb_valid),
        .q_ready  (qb_ready),
        .q_cmd    (qb_cmd),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule
